// ===== sv/bcdts_pkg.sv =====
// Package of types, codes and BCD helper functions for the BCD clock time setter.
`default_nettype none

package bcdts_pkg;

  // Event codes carried by an input word.
  typedef enum logic [1:0] {
    OP_MODE = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2,
    OP_TICK = 2'd3
  } opcode_t;

  // Field currently being set.
  typedef enum logic [1:0] {
    FIELD_NONE    = 2'd0,
    FIELD_SECONDS = 2'd1,
    FIELD_MINUTES = 2'd2,
    FIELD_HOURS   = 2'd3
  } field_t;

  // Clock chip register addresses.
  localparam logic [1:0] ADDR_SECONDS = 2'd0;
  localparam logic [1:0] ADDR_MINUTES = 2'd1;
  localparam logic [1:0] ADDR_HOURS   = 2'd2;

  // Configuration register map.
  localparam int          PADDR_W           = 3;
  localparam logic [2:0]  REG_TIMEOUT_LIMIT = 3'd0;
  localparam logic [7:0]  TIMEOUT_RESET     = 8'd10;

  // Wrap limits in BCD.
  localparam logic [6:0] MAX_MIN_SEC = 7'h59;
  localparam logic [6:0] MAX_HOURS   = 7'h23;

  typedef struct packed {
    opcode_t     opcode;
    logic [6:0]  rtc_seconds;
    logic [6:0]  rtc_minutes;
    logic [5:0]  rtc_hours;
  } in_word_t;

  typedef struct packed {
    logic        write_valid;
    logic [1:0]  write_address;
    logic [6:0]  write_data;
    field_t      adjust_field;
    logic [6:0]  show_seconds;
    logic [6:0]  show_minutes;
    logic [5:0]  show_hours;
  } out_word_t;

  // Step a BCD value by one through binary; odd digits are taken at face value.
  function automatic logic [6:0] bcd_step(input logic [6:0] v, input logic up);
    logic [6:0] bin;
    logic [3:0] tens;
    logic [6:0] rem;
    bin = {1'b0, v[6:4], 3'b000} + {3'b000, v[6:4], 1'b0} + {3'b000, v[3:0]};
    bin = up ? bin + 7'd1 : bin - 7'd1;
    // Split into digits; the value stays well below one hundred.
    if (bin >= 7'd90) begin
      tens = 4'd9; rem = bin - 7'd90;
    end else if (bin >= 7'd80) begin
      tens = 4'd8; rem = bin - 7'd80;
    end else if (bin >= 7'd70) begin
      tens = 4'd7; rem = bin - 7'd70;
    end else if (bin >= 7'd60) begin
      tens = 4'd6; rem = bin - 7'd60;
    end else if (bin >= 7'd50) begin
      tens = 4'd5; rem = bin - 7'd50;
    end else if (bin >= 7'd40) begin
      tens = 4'd4; rem = bin - 7'd40;
    end else if (bin >= 7'd30) begin
      tens = 4'd3; rem = bin - 7'd30;
    end else if (bin >= 7'd20) begin
      tens = 4'd2; rem = bin - 7'd20;
    end else if (bin >= 7'd10) begin
      tens = 4'd1; rem = bin - 7'd10;
    end else begin
      tens = 4'd0; rem = bin;
    end
    return {tens[2:0], rem[3:0]};
  endfunction

  // Up wraps to zero at or above the maximum; down goes to the maximum
  // from zero or from anything above the maximum.
  function automatic logic [6:0] bcd_adjust(input logic [6:0] v, input logic [6:0] maxv,
                                            input logic up);
    logic [6:0] res;
    if (up) begin
      res = (v >= maxv) ? 7'd0 : bcd_step(v, 1'b1);
    end else if (v == 7'd0 || v > maxv) begin
      res = maxv;
    end else begin
      res = bcd_step(v, 1'b0);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bcd_clock_time_setter_top.sv =====
// Top level of the BCD clock time setter: event decode, state, output buffer and APB port.
//
// Usage: each input word carries one event (mode key, up key, down key or a
// one-second tick with the time read from the clock chip). Every accepted
// word produces exactly one output word with an optional clock register
// write, the field being set and the held time for display.
// Both channels use valid and stall; a word moves on a rising edge with
// valid high and stall low. All work for a word is done in the cycle it is
// accepted, and its result is registered into the output or the skid register.
// Throughput is one word per cycle when not stalled, set by the single state update path.
// The output has a main register and a skid register, so a word is taken
// while a result is still waiting; in_stall rises only when both are full,
// and falls in the cycle after the receiver takes a word.
// Synchronous reset clears the state (no field, idle count zero, time 00:00:00),
// empties the output buffer and sets timeout_limit to 10. timeout_limit is written
// over APB at byte address 0; the user writes it only while idle, which is not enforced.
`default_nettype none

module bcd_clock_time_setter_top
  import bcdts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_word_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_word_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [7:0] timeout_limit;
  field_t     field_select, field_select_next;
  logic [7:0] idle_count, idle_count_next;
  logic [6:0] seconds_bcd, seconds_bcd_next;
  logic [6:0] minutes_bcd, minutes_bcd_next;
  logic [5:0] hours_bcd, hours_bcd_next;
  logic       wr_valid;
  logic [1:0] wr_addr;
  logic [6:0] wr_data;
  logic [6:0] hours_adj;
  logic       is_up;
  logic       in_accept;
  logic       out_take;
  out_word_t  result;
  out_word_t  skid_data;
  logic       skid_valid;

  // APB register port; always ready.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TIMEOUT_LIMIT) ? {24'd0, timeout_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_TIMEOUT_LIMIT) begin
      timeout_limit <= pwdata[7:0];
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = skid_valid;

  // Event decode and next state.
  assign is_up     = (in_data.opcode == OP_UP);
  assign hours_adj = bcd_adjust({1'b0, hours_bcd}, MAX_HOURS, is_up);

  always_comb begin
    field_select_next = field_select;
    idle_count_next   = idle_count;
    seconds_bcd_next  = seconds_bcd;
    minutes_bcd_next  = minutes_bcd;
    hours_bcd_next    = hours_bcd;
    wr_valid          = 1'b0;
    wr_addr           = ADDR_SECONDS;
    wr_data           = 7'd0;
    case (in_data.opcode)
      OP_MODE: begin
        field_select_next = field_t'(field_select + 2'd1);
        idle_count_next   = 8'd0;
      end
      OP_UP, OP_DOWN: begin
        idle_count_next = 8'd0;
        case (field_select)
          FIELD_SECONDS: begin
            seconds_bcd_next = bcd_adjust(seconds_bcd, MAX_MIN_SEC, is_up);
            wr_valid         = 1'b1;
            wr_addr          = ADDR_SECONDS;
            wr_data          = seconds_bcd_next;
          end
          FIELD_MINUTES: begin
            minutes_bcd_next = bcd_adjust(minutes_bcd, MAX_MIN_SEC, is_up);
            wr_valid         = 1'b1;
            wr_addr          = ADDR_MINUTES;
            wr_data          = minutes_bcd_next;
          end
          FIELD_HOURS: begin
            hours_bcd_next = hours_adj[5:0];
            wr_valid       = 1'b1;
            wr_addr        = ADDR_HOURS;
            wr_data        = hours_adj;
          end
          default: begin
            wr_valid = 1'b0;
          end
        endcase
      end
      OP_TICK: begin
        if (idle_count < timeout_limit) begin
          idle_count_next = idle_count + 8'd1;
        end else begin
          field_select_next = FIELD_NONE;
        end
        seconds_bcd_next = in_data.rtc_seconds;
        minutes_bcd_next = in_data.rtc_minutes;
        hours_bcd_next   = in_data.rtc_hours;
      end
      default: begin
        field_select_next = field_select;
      end
    endcase
  end

  // Result word for the event being accepted.
  always_comb begin
    result.write_valid   = wr_valid;
    result.write_address = wr_addr;
    result.write_data    = wr_data;
    result.adjust_field  = field_select_next;
    result.show_seconds  = seconds_bcd_next;
    result.show_minutes  = minutes_bcd_next;
    result.show_hours    = hours_bcd_next;
  end

  // Controller state, updated on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_select <= FIELD_NONE;
      idle_count   <= 8'd0;
      seconds_bcd  <= 7'd0;
      minutes_bcd  <= 7'd0;
      hours_bcd    <= 6'd0;
    end else if (in_accept) begin
      field_select <= field_select_next;
      idle_count   <= idle_count_next;
      seconds_bcd  <= seconds_bcd_next;
      minutes_bcd  <= minutes_bcd_next;
      hours_bcd    <= hours_bcd_next;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!out_valid || out_take) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end else if (out_take && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

`default_nettype wire
